@@ rtl/hfm3_pkg.sv @@
package hfm3_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;
    localparam int RECIP_W = 17;
    localparam int RECIP_SHIFT = 16;

    localparam logic [PIX_W-1:0] THRESH_RESET = 8'd30;
    localparam logic [2:0] REG_THRESH_ADDR = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_PUSH
    } hfm3_state_t;

    typedef struct packed {
        logic idle;
        logic sum_en;
        logic flush;
        logic div_en;
        logic push;
        logic last;
    } hfm3_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic centre_valid;
        logic line_end;
        logic out_free;
    } hfm3_status_t;

    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/hfm3_if.sv @@
interface hfm3_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] top_pixel;
    logic [7:0] mid_pixel;
    logic [7:0] bottom_pixel;
    logic       top_present;
    logic       bottom_present;
    logic       line_start;
    logic       line_end;

    modport source (
        output valid, top_pixel, mid_pixel, bottom_pixel,
        output top_present, bottom_present, line_start, line_end,
        input  ready
    );
    modport sink (
        input  valid, top_pixel, mid_pixel, bottom_pixel,
        input  top_present, bottom_present, line_start, line_end,
        output ready
    );
endinterface

interface hfm3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_pixel;
    logic       was_filled;
    logic       no_neighbours;
    logic       last_of_run;

    modport source (
        output valid, out_pixel, was_filled, no_neighbours, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_pixel, was_filled, no_neighbours, last_of_run,
        output ready
    );
endinterface

@@ rtl/hfm3_ctrl.sv @@
module hfm3_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hfm3_pkg::hfm3_status_t status,
    output hfm3_pkg::hfm3_cmd_t    cmd
);

    hfm3_pkg::hfm3_state_t state_reg, state_next;
    logic                  phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= hfm3_pkg::ST_IDLE;
            phase_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            hfm3_pkg::ST_IDLE: begin
                if (status.in_valid) begin
                    state_next = hfm3_pkg::ST_SUM;
                    phase_next = 1'b0;
                end
            end
            hfm3_pkg::ST_SUM: begin
                priority if (phase_reg || status.centre_valid) begin
                    state_next = hfm3_pkg::ST_DIV;
                end
                else if (status.line_end) begin
                    phase_next = 1'b1;
                end
                else begin
                    state_next = hfm3_pkg::ST_IDLE;
                end
            end
            hfm3_pkg::ST_DIV: begin
                state_next = hfm3_pkg::ST_PUSH;
            end
            hfm3_pkg::ST_PUSH: begin
                if (status.out_free) begin
                    if (!phase_reg && status.line_end) begin
                        state_next = hfm3_pkg::ST_SUM;
                        phase_next = 1'b1;
                    end
                    else begin
                        state_next = hfm3_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = hfm3_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.flush  = phase_reg;
        cmd.last   = phase_reg || !status.line_end;
        unique case (state_reg)
            hfm3_pkg::ST_IDLE: cmd.idle   = 1'b1;
            hfm3_pkg::ST_SUM:  cmd.sum_en = 1'b1;
            hfm3_pkg::ST_DIV:  cmd.div_en = 1'b1;
            hfm3_pkg::ST_PUSH: cmd.push   = status.out_free;
            default:           cmd.idle   = 1'b0;
        endcase
    end

    a_capture_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.idle && status.in_valid) |=> (state_reg == hfm3_pkg::ST_SUM && !phase_reg))
        else $error("accepted request did not start a window sum");

    a_flush_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sum_en && cmd.flush) |=> (state_reg == hfm3_pkg::ST_DIV))
        else $error("line-end flush skipped its result");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> status.out_free)
        else $error("result pushed into a full output register");

    a_push_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> !status.in_valid || !cmd.sum_en || state_reg == hfm3_pkg::ST_SUM)
        else $error("push left the sequencer in a bad state");

endmodule

@@ rtl/hfm3_datapath.sv @@
module hfm3_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             threshold,
    input  hfm3_pkg::hfm3_cmd_t    cmd,
    output hfm3_pkg::hfm3_status_t status,
    hfm3_in_if.sink                in_ch,
    hfm3_out_if.source             out_ch
);

    logic [hfm3_pkg::PIX_W-1:0] left_reg   [3];
    logic [hfm3_pkg::PIX_W-1:0] centre_reg [3];
    logic [hfm3_pkg::PIX_W-1:0] col_reg    [3];
    logic [hfm3_pkg::PIX_W-1:0] col_next   [3];
    logic [hfm3_pkg::PIX_W-1:0] right      [3];
    logic                       centre_valid_reg;
    logic                       line_end_reg;

    logic [hfm3_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [hfm3_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [hfm3_pkg::PIX_W-1:0] c_reg;
    logic [hfm3_pkg::PIX_W-1:0] mean_reg;
    logic [hfm3_pkg::SUM_W+hfm3_pkg::RECIP_W-1:0] prod;

    logic                       out_valid_reg;
    logic [hfm3_pkg::PIX_W-1:0] out_pixel_reg;
    logic                       was_filled_reg;
    logic                       no_neighbours_reg;
    logic                       last_reg;

    logic capture;

    function automatic logic [7:0] keep_present(input logic [7:0] p, input logic row_ok,
                                                input logic [7:0] th);
        logic [7:0] r;
        r = (!row_ok || p == 8'd0 || p < th) ? 8'd0 : p;
        return r;
    endfunction

    assign capture = cmd.idle && in_ch.valid;
    assign in_ch.ready = cmd.idle;

    always_comb begin
        col_next[0] = keep_present(in_ch.top_pixel, in_ch.top_present, threshold);
        col_next[1] = keep_present(in_ch.mid_pixel, 1'b1, threshold);
        col_next[2] = keep_present(in_ch.bottom_pixel, in_ch.bottom_present, threshold);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            right[i] = cmd.flush ? '0 : col_reg[i];
        end
    end

    always_comb begin
        sum_next = '0;
        cnt_next = '0;
        for (int i = 0; i < 3; i++) begin
            sum_next = sum_next + hfm3_pkg::SUM_W'(left_reg[i])
                     + hfm3_pkg::SUM_W'(centre_reg[i]) + hfm3_pkg::SUM_W'(right[i]);
            cnt_next = cnt_next + hfm3_pkg::CNT_W'(left_reg[i] != '0)
                     + hfm3_pkg::CNT_W'(centre_reg[i] != '0)
                     + hfm3_pkg::CNT_W'(right[i] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) begin
                left_reg[i]   <= '0;
                centre_reg[i] <= '0;
            end
            centre_valid_reg <= 1'b0;
        end
        else if (capture && in_ch.line_start) begin
            for (int i = 0; i < 3; i++) begin
                left_reg[i]   <= '0;
                centre_reg[i] <= '0;
            end
            centre_valid_reg <= 1'b0;
        end
        else if (cmd.sum_en) begin
            for (int i = 0; i < 3; i++) begin
                left_reg[i]   <= cmd.flush ? '0 : centre_reg[i];
                centre_reg[i] <= cmd.flush ? '0 : col_reg[i];
            end
            centre_valid_reg <= !cmd.flush;
        end
    end

    always_ff @(posedge clk) begin
        if (capture) begin
            col_reg      <= col_next;
            line_end_reg <= in_ch.line_end;
        end
        if (cmd.sum_en) begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            c_reg   <= centre_reg[1];
        end
        if (cmd.div_en) begin
            mean_reg <= prod[hfm3_pkg::RECIP_SHIFT +: hfm3_pkg::PIX_W];
        end
    end

    assign prod = (hfm3_pkg::SUM_W+hfm3_pkg::RECIP_W)'(sum_reg)
                * (hfm3_pkg::SUM_W+hfm3_pkg::RECIP_W)'(hfm3_pkg::recip_lookup(cnt_reg));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.push) begin
            if (c_reg != '0) begin
                out_pixel_reg     <= c_reg;
                was_filled_reg    <= 1'b0;
                no_neighbours_reg <= 1'b0;
            end
            else begin
                out_pixel_reg     <= mean_reg;
                was_filled_reg    <= 1'b1;
                no_neighbours_reg <= (cnt_reg == '0);
            end
            last_reg <= cmd.last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_pixel     = out_pixel_reg;
    assign out_ch.was_filled    = was_filled_reg;
    assign out_ch.no_neighbours = no_neighbours_reg;
    assign out_ch.last_of_run   = last_reg;

    assign status.in_valid     = in_ch.valid;
    assign status.centre_valid = centre_valid_reg;
    assign status.line_end     = line_end_reg;
    assign status.out_free     = !out_valid_reg || out_ch.ready;

endmodule

@@ rtl/hole_fill_masked_mean_3x3_core.sv @@
// Each result steps through the one shared sum and reciprocal multiply path: the window
// sum (SUM), the multiply (DIV) and the push to the output register (PUSH), which waits
// while that register is full. A column that only leaves its pixel pending returns to
// IDLE after SUM; line_end adds a pass flushing the last pixel; columns enter in IDLE.
// Reset (rst_n, async, active low): window cleared to all missing, threshold 30,
// output empty.
module hole_fill_masked_mean_3x3_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    hfm3_in_if.sink     in_ch,
    hfm3_out_if.source  out_ch
);

    logic [7:0]             thresh_reg;
    hfm3_pkg::hfm3_cmd_t    cmd;
    hfm3_pkg::hfm3_status_t status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= hfm3_pkg::THRESH_RESET;
        end
        else if (psel && penable && pwrite && paddr == hfm3_pkg::REG_THRESH_ADDR)
        begin
            thresh_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == hfm3_pkg::REG_THRESH_ADDR) ? {24'd0, thresh_reg} : 32'd0;

    hfm3_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    hfm3_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thresh_reg),
        .cmd       (cmd),
        .status    (status),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

@@ dv/hole_fill_masked_mean_3x3_core_test.sv @@
`timescale 1ns / 1ps

module hole_fill_masked_mean_3x3_core_test;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_LIMIT  = 30;

    typedef struct {
        logic [7:0] top_pixel;
        logic [7:0] mid_pixel;
        logic [7:0] bottom_pixel;
        logic       top_present;
        logic       bottom_present;
        logic       line_start;
        logic       line_end;
    } column_t;

    typedef struct {
        logic [7:0] out_pixel;
        logic       was_filled;
        logic       no_neighbours;
        logic       last_of_run;
    } pixel_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hfm3_in_if  column_ch ();
    hfm3_out_if pixel_ch ();

    hole_fill_masked_mean_3x3_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (column_ch.sink),
        .out_ch  (pixel_ch.source)
    );

    column_t       pending_columns[$];
    pixel_result_t expected_pixels[$];
    column_t       bus_column;
    pixel_result_t want;

    logic [7:0] hole_thresh;
    logic [7:0] left_col [3];
    logic [7:0] centre_col [3];
    logic       centre_pending;

    int error_count;
    int cycle_count;
    int send_gap;
    int send_calm;
    int recv_stall;
    int recv_calm;
    logic recv_ready_next;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [7:0] keep_pixel(input logic [7:0] p, input logic row_ok);
        return (!row_ok || p == 8'd0 || p < hole_thresh) ? 8'd0 : p;
    endfunction

    function automatic pixel_result_t window_result(input logic [7:0] right_col [3]);
        pixel_result_t r;
        int sum;
        int cnt;
        sum = 0;
        cnt = 0;
        r.last_of_run = 1'b0;
        if (centre_col[1] != 8'd0)
        begin
            r.out_pixel     = centre_col[1];
            r.was_filled    = 1'b0;
            r.no_neighbours = 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (left_col[i] != 8'd0)
                begin
                    sum += left_col[i];
                    cnt++;
                end
                if (centre_col[i] != 8'd0)
                begin
                    sum += centre_col[i];
                    cnt++;
                end
                if (right_col[i] != 8'd0)
                begin
                    sum += right_col[i];
                    cnt++;
                end
            end
            r.out_pixel     = (cnt != 0) ? 8'(sum / cnt) : 8'd0;
            r.was_filled    = 1'b1;
            r.no_neighbours = (cnt == 0);
        end
        return r;
    endfunction

    task automatic clear_window();
        left_col       = '{default: 8'd0};
        centre_col     = '{default: 8'd0};
        centre_pending = 1'b0;
    endtask

    task automatic predict_column(input column_t c);
        logic [7:0] right_col [3];
        logic [7:0] none_col [3];
        pixel_result_t res [2];
        int n;
        n = 0;
        none_col = '{default: 8'd0};
        if (c.line_start)
            clear_window();
        right_col[0] = keep_pixel(c.top_pixel, c.top_present);
        right_col[1] = keep_pixel(c.mid_pixel, 1'b1);
        right_col[2] = keep_pixel(c.bottom_pixel, c.bottom_present);
        if (centre_pending)
        begin
            res[n] = window_result(right_col);
            n++;
        end
        left_col       = centre_col;
        centre_col     = right_col;
        centre_pending = 1'b1;
        if (c.line_end)
        begin
            res[n] = window_result(none_col);
            n++;
            clear_window();
        end
        if (n > 0)
            res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_pixels.insert(expected_pixels.size(), res[i]);
    endtask

    function automatic int pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // Drive one request per handshake, then hold off for a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_ch.valid          <= 1'b0;
            column_ch.top_pixel      <= 8'd0;
            column_ch.mid_pixel      <= 8'd0;
            column_ch.bottom_pixel   <= 8'd0;
            column_ch.top_present    <= 1'b0;
            column_ch.bottom_present <= 1'b0;
            column_ch.line_start     <= 1'b0;
            column_ch.line_end       <= 1'b0;
            send_gap  = 0;
            send_calm = 0;
        end
        else
        begin
            if (column_ch.valid && column_ch.ready)
                predict_column(bus_column);
            if (!column_ch.valid || column_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    column_ch.valid <= 1'b0;
                end
                else if (pending_columns.size() != 0)
                begin
                    bus_column = pending_columns.pop_front();
                    column_ch.top_pixel      <= bus_column.top_pixel;
                    column_ch.mid_pixel      <= bus_column.mid_pixel;
                    column_ch.bottom_pixel   <= bus_column.bottom_pixel;
                    column_ch.top_present    <= bus_column.top_present;
                    column_ch.bottom_present <= bus_column.bottom_present;
                    column_ch.line_start     <= bus_column.line_start;
                    column_ch.line_end       <= bus_column.line_end;
                    column_ch.valid          <= 1'b1;
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = pick_pause();
                        if ($urandom_range(0, 49) == 0)
                            send_calm = $urandom_range(20, 60);
                    end
                end
                else
                    column_ch.valid <= 1'b0;
            end
        end
    end

    // Check each result against the oldest expectation; stall ready at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ch.ready <= 1'b0;
            recv_stall = 0;
            recv_calm  = 0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("result with none expected: pixel %0d",
                                              pixel_ch.out_pixel));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_ch.out_pixel !== want.out_pixel
                        || pixel_ch.was_filled !== want.was_filled
                        || pixel_ch.no_neighbours !== want.no_neighbours
                        || pixel_ch.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf(
                            "got pixel %0d fill %b none %b last %b, want %0d %b %b %b",
                            pixel_ch.out_pixel, pixel_ch.was_filled,
                            pixel_ch.no_neighbours, pixel_ch.last_of_run,
                            want.out_pixel, want.was_filled,
                            want.no_neighbours, want.last_of_run));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                recv_ready_next = 1'b0;
            end
            else
            begin
                recv_ready_next = 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 3) == 0)
                begin
                    recv_stall = pick_pause();
                    if ($urandom_range(0, 29) == 0)
                        recv_calm = $urandom_range(20, 80);
                end
            end
            pixel_ch.ready <= recv_ready_next;
        end
    end

    task automatic add_column(input logic [7:0] top, input logic [7:0] mid,
                              input logic [7:0] bottom, input logic top_ok,
                              input logic bottom_ok, input logic start, input logic stop);
        column_t c;
        c.top_pixel      = top;
        c.mid_pixel      = mid;
        c.bottom_pixel   = bottom;
        c.top_present    = top_ok;
        c.bottom_present = bottom_ok;
        c.line_start     = start;
        c.line_end       = stop;
        pending_columns.insert(pending_columns.size(), c);
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 9))
            0, 1: return 8'd0;
            2: return hole_thresh - 8'd1;
            3: return hole_thresh;
            4: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_threshold(input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hfm3_pkg::REG_THRESH_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hole_thresh = value;
    endtask

    task automatic wait_idle();
        while (pending_columns.size() != 0 || column_ch.valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly whole rows with random content; some rows lose a mark, some noise.
    task automatic add_random_columns(input int budget);
        int added;
        int width;
        int unsigned kind;
        logic top_ok;
        logic bottom_ok;
        added = 0;
        while (added < budget)
        begin
            kind      = $urandom_range(0, 19);
            width     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            top_ok    = ($urandom_range(0, 4) != 0);
            bottom_ok = ($urandom_range(0, 4) != 0);
            if (kind < 18)
            begin
                for (int x = 0; x < width; x++)
                    add_column(pick_pixel(), pick_pixel(), pick_pixel(), top_ok, bottom_ok,
                               (x == 0) && (kind != 16 && kind != 17),
                               (x == width - 1) && (kind != 14 && kind != 15));
                added += width;
            end
            else
            begin
                width = $urandom_range(1, 4);
                for (int x = 0; x < width; x++)
                    add_column(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                               1'($urandom), 1'($urandom), 1'($urandom));
                added += width;
            end
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        column_ch.valid          = 1'b0;
        column_ch.top_pixel      = 8'd0;
        column_ch.mid_pixel      = 8'd0;
        column_ch.bottom_pixel   = 8'd0;
        column_ch.top_present    = 1'b0;
        column_ch.bottom_present = 1'b0;
        column_ch.line_start     = 1'b0;
        column_ch.line_end       = 1'b0;
        pixel_ch.ready           = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hole_thresh = hfm3_pkg::THRESH_RESET;
        clear_window();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // one pixel wide row, centre filled from above and below
        add_column(8'd200, 8'd0, 8'd100, 1'b1, 1'b1, 1'b1, 1'b1);
        // all-missing window
        add_column(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0);
        add_column(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
        add_column(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1);
        // extremes around the threshold
        add_column(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b0);
        add_column(8'd255, 8'd0, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0);
        add_column(8'd255, 8'd29, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0);
        add_column(8'd30, 8'd30, 8'd29, 1'b1, 1'b1, 1'b0, 1'b1);
        // rows outside the image
        add_column(8'd255, 8'd10, 8'd255, 1'b0, 1'b0, 1'b1, 1'b0);
        add_column(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1'b1);
        // row without an end, dropped by the next start
        add_column(8'd90, 8'd80, 8'd70, 1'b1, 1'b1, 1'b1, 1'b0);
        add_column(8'd60, 8'd0, 8'd50, 1'b1, 1'b1, 1'b0, 1'b0);
        add_column(8'd40, 8'd0, 8'd45, 1'b1, 1'b0, 1'b1, 1'b0);
        add_column(8'd0, 8'd120, 8'd0, 1'b1, 1'b0, 1'b0, 1'b1);
        // columns after an end without a start
        add_column(8'd100, 8'd0, 8'd100, 1'b1, 1'b1, 1'b0, 1'b0);
        add_column(8'd0, 8'd77, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
        add_column(8'd31, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1);
        add_random_columns(140);
        wait_idle();

        write_threshold(8'd0);
        add_random_columns(140);
        wait_idle();

        write_threshold(8'd255);
        add_random_columns(120);
        wait_idle();

        for (int phase = 0; phase < 3; phase++)
        begin
            write_threshold(8'($urandom_range(1, 254)));
            add_random_columns(130);
            wait_idle();
        end

        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
